[rtl/bsc_pkg.sv]
// shared types and constants for the barometric sensor compensation block
// no dependencies
package bsc_pkg;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      word_type quotient;
   } div_rsp_type;

   localparam logic CMD_TEMPERATURE = 1'b0;
   localparam logic CMD_PRESSURE    = 1'b1;

   localparam logic [7:0] REG_CAL_A = 8'd0;
   localparam logic [7:0] REG_CAL_B = 8'd1;
   localparam logic [7:0] REG_CAL_C = 8'd2;
   localparam logic [7:0] REG_OSS   = 8'd3;

   localparam logic signed [31:0] B6_OFFSET   = 32'sd4000;
   localparam logic signed [31:0] CORR_SQ     = 32'sd3038;
   localparam logic signed [31:0] CORR_LIN    = -32'sd7357;
   localparam logic signed [31:0] CORR_OFFSET = 32'sd3791;
   localparam word_type           B7_SCALE    = 32'd50000;
   localparam word_type           DIV_SPLIT   = 32'h8000_0000;
   localparam logic signed [31:0] B4_OFFSET   = 32'sd32768;

endpackage

[rtl/barometric_sensor_compensation.sv]
// top level: sequencer, calibration registers and result register
// depends on bsc_pkg, bsc_mul, bsc_div
//
// Fixed-point temperature and pressure compensation for a barometric sensor.
// One transaction is taken at a time: a reading passes through the bit-serial
// divider and the chain of up to ten products through the single shared
// multiplier, and its result is then loaded into the result register.
// req_stall is high
// while a reading is in work. A finished result waits in the output register
// while the next transaction is accepted. Calibration registers are written
// through the csr_ port, which is always ready; indexes beyond three are
// ignored. A zero divisor gives a zero result with divide_error set.
module barometric_sensor_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [23:0] req_raw_reading,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic signed [15:0] rsp_temperature_tenths,
   output logic [19:0] rsp_pressure_pascal,
   output logic        rsp_divide_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_data
);
   import bsc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, T_MUL, T_DEN, T_DIV,
      P_SQ, P_X1, P_X2, P_B3, P_X4, P_B4, P_B7, P_DIVS, P_DIV,
      P_C1, P_C2, P_C3, S_DONE
   } state_type;

   state_type state_ff;

   // calibration
   logic [63:0] cal_a_ff, cal_b_ff;
   logic [31:0] cal_c_ff;
   logic [1:0]  oss_ff;

   // work registers
   logic        cmd_ff;
   logic [23:0] raw_ff;
   logic signed [31:0] b5_ff, x1_ff, b6_ff, sq_ff, b3_ff, p_ff;
   word_type    b4_ff;
   logic        neg_ff, dbl_ff;

   // pending result
   logic        pend_err_ff;
   logic signed [15:0] pend_t_ff;
   logic [19:0] pend_p_ff;

   logic        rsp_valid_ff, rsp_kind_ff, rsp_err_ff;
   logic signed [15:0] rsp_t_ff;
   logic [19:0] rsp_p_ff;
   logic        rsp_load;

   word_type    mul_a, mul_b, prod;
   div_req_type dreq;
   div_rsp_type drsp;

   logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
   word_type    ac4, ac5, ac6;
   logic signed [31:0] sprod;

   // combinational stage values
   logic signed [31:0] t_x1, t_den, t_num, t_q, t_b5, t_t;
   logic signed [31:0] p_b6, p_sq, p_x3, p_v, p_b3, p_x3b, p_p, p_x2, p_fin;
   word_type    p_up, p_b7, p_q;

   assign ac1 = 32'(signed'(cal_a_ff[15:0]));
   assign ac2 = 32'(signed'(cal_a_ff[31:16]));
   assign ac3 = 32'(signed'(cal_a_ff[47:32]));
   assign ac4 = {16'b0, cal_a_ff[63:48]};
   assign ac5 = {16'b0, cal_b_ff[15:0]};
   assign ac6 = {16'b0, cal_b_ff[31:16]};
   assign b1  = 32'(signed'(cal_b_ff[47:32]));
   assign b2  = 32'(signed'(cal_b_ff[63:48]));
   assign mc  = 32'(signed'(cal_c_ff[15:0]));
   assign md  = 32'(signed'(cal_c_ff[31:16]));
   assign sprod = signed'(prod);

   bsc_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod(prod));
   bsc_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      // temperature path
      t_x1  = sprod >>> 15;
      t_den = t_x1 + md;
      t_num = mc <<< 11;
      t_q   = neg_ff ? -signed'(drsp.quotient) : signed'(drsp.quotient);
      t_b5  = x1_ff + t_q;
      t_t   = (t_b5 + 32'sd8) >>> 4;
      // pressure path
      p_b6  = b5_ff - B6_OFFSET;
      p_sq  = sprod >>> 12;
      p_x3  = x1_ff + (sprod >>> 11);
      p_v   = ((((ac1 <<< 2) + p_x3) <<< oss_ff) + 32'sd2);
      // divide by four truncating toward zero
      p_b3  = (p_v + (p_v[31] ? 32'sd3 : 32'sd0)) >>> 2;
      p_x3b = (x1_ff + (sprod >>> 16) + 32'sd2) >>> 2;
      p_up  = {8'b0, raw_ff} >> (4'd8 - {2'b0, oss_ff});
      p_b7  = prod;
      p_q   = dbl_ff ? {drsp.quotient[30:0], 1'b0} : drsp.quotient;
      p_p   = signed'(p_q);
      p_x2  = sprod >>> 16;
      p_fin = p_ff + ((x1_ff + p_x2 + CORR_OFFSET) >>> 4);
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         T_MUL: begin
            mul_a = {16'b0, raw_ff[15:0]} - ac6;
            mul_b = ac5;
         end
         P_SQ: begin
            mul_a = p_b6;
            mul_b = p_b6;
         end
         P_X1: begin
            mul_a = b2;
            mul_b = p_sq;
         end
         P_X2: begin
            mul_a = ac2;
            mul_b = b6_ff;
         end
         P_B3: begin
            mul_a = ac3;
            mul_b = b6_ff;
         end
         P_X4: begin
            mul_a = b1;
            mul_b = sq_ff;
         end
         P_B4: begin
            mul_a = ac4;
            mul_b = p_x3b + B4_OFFSET;
         end
         P_B7: begin
            mul_a = p_up - b3_ff;
            mul_b = B7_SCALE >> oss_ff;
         end
         P_DIV: begin
            mul_a = p_p >>> 8;
            mul_b = p_p >>> 8;
         end
         P_C1: begin
            mul_a = prod;
            mul_b = CORR_SQ;
         end
         P_C2: begin
            mul_a = CORR_LIN;
            mul_b = p_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // divider start
   always_comb begin
      dreq.start    = 1'b0;
      dreq.dividend = '0;
      dreq.divisor  = '0;
      if (state_ff == T_DEN && t_den != 32'sd0) begin
         dreq.start    = 1'b1;
         dreq.dividend = t_num[31] ? -t_num : t_num;
         dreq.divisor  = t_den[31] ? -t_den : t_den;
      end else if (state_ff == P_DIVS && b4_ff != '0) begin
         dreq.start    = 1'b1;
         // unsigned split keeps the doubled dividend inside 32 bits
         dreq.dividend = (p_b7 < DIV_SPLIT) ? {p_b7[30:0], 1'b0} : p_b7;
         dreq.divisor  = b4_ff;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // output register takes the finished result once it is free
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cal_a_ff     <= '0;
         cal_b_ff     <= '0;
         cal_c_ff     <= '0;
         oss_ff       <= '0;
         b5_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // configuration writes
         if (csr_valid) begin
            case (csr_index)
               REG_CAL_A: cal_a_ff <= csr_data;
               REG_CAL_B: cal_b_ff <= csr_data;
               REG_CAL_C: cal_c_ff <= csr_data[31:0];
               REG_OSS:   oss_ff   <= csr_data[1:0];
               default:   ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff      <= req_cmd;
                  raw_ff      <= req_raw_reading;
                  pend_err_ff <= 1'b0;
                  pend_t_ff   <= '0;
                  pend_p_ff   <= '0;
                  state_ff    <= (req_cmd == CMD_PRESSURE) ? P_SQ : T_MUL;
               end
            end
            T_MUL: state_ff <= T_DEN;
            T_DEN: begin
               x1_ff  <= t_x1;
               neg_ff <= t_num[31] ^ t_den[31];
               if (t_den == 32'sd0) begin
                  pend_err_ff <= 1'b1;
                  state_ff    <= S_DONE;
               end else begin
                  state_ff <= T_DIV;
               end
            end
            T_DIV: begin
               if (drsp.done) begin
                  b5_ff <= t_b5;
                  if (t_t > 32'sd32767) begin
                     pend_t_ff <= 16'sh7fff;
                  end else if (t_t < -32'sd32768) begin
                     pend_t_ff <= -16'sh8000;
                  end else begin
                     pend_t_ff <= t_t[15:0];
                  end
                  state_ff <= S_DONE;
               end
            end
            P_SQ: begin
               b6_ff    <= p_b6;
               state_ff <= P_X1;
            end
            P_X1: begin
               sq_ff    <= p_sq;
               state_ff <= P_X2;
            end
            P_X2: begin
               x1_ff    <= sprod >>> 11;
               state_ff <= P_B3;
            end
            P_B3: begin
               b3_ff    <= p_b3;
               state_ff <= P_X4;
            end
            P_X4: begin
               x1_ff    <= sprod >>> 13;
               state_ff <= P_B4;
            end
            P_B4: state_ff <= P_B7;
            P_B7: begin
               b4_ff    <= prod >> 15;
               state_ff <= P_DIVS;
            end
            P_DIVS: begin
               dbl_ff <= (p_b7 >= DIV_SPLIT);
               if (b4_ff == '0) begin
                  pend_err_ff <= 1'b1;
                  state_ff    <= S_DONE;
               end else begin
                  state_ff <= P_DIV;
               end
            end
            P_DIV: begin
               if (drsp.done) begin
                  p_ff     <= p_p;
                  state_ff <= P_C1;
               end
            end
            P_C1: state_ff <= P_C2;
            P_C2: begin
               x1_ff    <= sprod >>> 16;
               state_ff <= P_C3;
            end
            P_C3: begin
               if (p_fin < 32'sd0) begin
                  pend_p_ff <= '0;
               end else if (p_fin > 32'sd1048575) begin
                  pend_p_ff <= 20'hfffff;
               end else begin
                  pend_p_ff <= p_fin[19:0];
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      if (rsp_load) begin
         rsp_kind_ff <= cmd_ff;
         rsp_err_ff  <= pend_err_ff;
         rsp_t_ff    <= pend_t_ff;
         rsp_p_ff    <= pend_p_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_kind        = rsp_kind_ff;
   assign rsp_temperature_tenths = rsp_t_ff;
   assign rsp_pressure_pascal    = rsp_p_ff;
   assign rsp_divide_error       = rsp_err_ff;
endmodule

[rtl/bsc_mul.sv]
// shared 32x32 multiplier, low word of the product, registered
// depends on bsc_pkg
module bsc_mul (
   input  logic              clock,
   input  bsc_pkg::word_type op_a,
   input  bsc_pkg::word_type op_b,
   output bsc_pkg::word_type prod
);
   import bsc_pkg::*;

   word_type prod_ff;
   word_type prod_in;

   assign prod_in = word_type'(op_a * op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

[rtl/bsc_div.sv]
// unsigned 32-bit restoring divider, one quotient bit per cycle
// depends on bsc_pkg
module bsc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bsc_pkg::div_req_type req,
   output bsc_pkg::div_rsp_type rsp
);
   import bsc_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  count_ff, count_in;
   logic [32:0] rem_ff, rem_in;
   word_type    quo_ff, quo_in;
   word_type    dsr_ff, dsr_in;
   logic [32:0] rem_sh;
   logic        ge;

   always_comb begin
      rem_sh   = {rem_ff[31:0], quo_ff[31]};
      ge       = rem_sh >= {1'b0, dsr_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = req.dividend;
         dsr_in   = req.divisor;
      end else if (busy_ff) begin
         rem_in   = ge ? rem_sh - {1'b0, dsr_ff} : rem_sh;
         quo_in   = {quo_ff[30:0], ge};
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
